// ----- design/msbs_pkg.sv -----
// Package for the wildcard byte signature scanner.
// Holds sizes, payload and register types and the pattern byte selector.
// No dependencies; every design file refers to it by scoped names.
package msbs_pkg;

	// Window depth, one cell per pattern byte
	localparam int PATTERN_MAX = 16;
	// Width of the running byte count
	localparam int OFFSET_BITS = 32;
	// Pattern register widths as fixed by the register map
	localparam int PAT_BYTES   = 16;
	localparam int LEN_W       = 5;
	localparam int CFG_IDX_W   = 8;
	localparam int CFG_DATA_W  = 64;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT_LOW  = 8'd0,
		REG_PAT_HIGH = 8'd1,
		REG_CARE     = 8'd2,
		REG_LENGTH   = 8'd3
	} cfg_reg_e;

	// Input request
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} scan_in_t;

	// Result request
	typedef struct packed {
		logic        found;
		logic [31:0] match_offset;
	} scan_out_t;

	// One window entry as it moves along the chain
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} win_entry_t;

	// Per-cell comparison setup
	typedef struct packed {
		logic [7:0] pat;
		logic       care;
		logic       in_use;
	} cell_cfg_t;

	// Pick pattern byte idx out of the 128-bit pattern, byte 0 in the low bits
	function automatic logic [7:0] pat_byte(input logic [8*PAT_BYTES-1:0] pat,
			input logic [3:0] idx);
		return pat[8*idx +: 8];
	endfunction

endpackage

// ----- design/msbs_cell.sv -----
// One window cell of the signature scanner chain.
// Holds one byte with its valid bit and compares the byte it is about to load.
// Depends on msbs_pkg.
module msbs_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   shift,
	input  logic                   clear,
	input  msbs_pkg::win_entry_t   d,
	input  msbs_pkg::cell_cfg_t    cfg,
	output msbs_pkg::win_entry_t   q,
	output logic                   hit
);

	logic       valid_q;
	logic [7:0] data_q;

	// Pass when unused, or when a real byte arrives that fits the pattern
	assign hit = !cfg.in_use || (d.valid && (!cfg.care || (d.data == cfg.pat)));

	// Load from the neighbour; drop validity at end of image
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= d.valid && !clear;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= d.data;
		end
	end

	assign q = '{valid: valid_q, data: data_q};

endmodule

// ----- design/msbs_out_buf.sv -----
// Two-entry result buffer: output register plus skid slot.
// Lets the scanner keep taking bytes while a result waits. Depends on msbs_pkg.
module msbs_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  msbs_pkg::scan_out_t  push_item,
	output logic                 full,
	output logic                 out_valid,
	input  logic                 out_ready,
	output msbs_pkg::scan_out_t  out_item
);

	logic                main_v_q;
	logic                skid_v_q;
	msbs_pkg::scan_out_t main_q;
	msbs_pkg::scan_out_t skid_q;
	logic                main_adv;

	assign main_adv = !main_v_q || out_ready;

	// Control: refill the output stage from skid first, then from a new request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (main_adv) begin
			main_v_q <= skid_v_q || push;
			skid_v_q <= skid_v_q && push;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (main_adv) begin
			if (skid_v_q) begin
				main_q <= skid_q;
				if (push) begin
					skid_q <= push_item;
				end
			end else if (push) begin
				main_q <= push_item;
			end
		end else if (push) begin
			skid_q <= push_item;
		end
	end

	assign full      = skid_v_q;
	assign out_valid = main_v_q;
	assign out_item  = main_q;

endmodule

// ----- design/masked_byte_signature_scan_top.sv -----
// Wildcard byte signature scanner: takes one image byte per clock through a chain of
// window cells, each comparing its incoming byte with the pattern byte for its place, and
// reports the start offset of the first match once per image, or not-found on the last
// byte. Throughput is one byte per cycle; a result is registered in the output register, or in
// the skid slot while that waits. Input stalls only when both result slots are full. The user
// must write the pattern, care mask and length registers only between images or while idle;
// the block itself does not enforce it. Depends on msbs_pkg, msbs_cell and msbs_out_buf.
module masked_byte_signature_scan_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [msbs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [msbs_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  msbs_pkg::scan_in_t                  in_item,
	output logic                                out_valid,
	input  logic                                out_ready,
	output msbs_pkg::scan_out_t                 out_item
);

	localparam int PMAX = msbs_pkg::PATTERN_MAX;
	localparam int OB   = msbs_pkg::OFFSET_BITS;

	logic [63:0]                   pat_lo_q;
	logic [63:0]                   pat_hi_q;
	logic [15:0]                   care_q;
	logic [msbs_pkg::LEN_W-1:0]    len_q;
	logic [msbs_pkg::LEN_W-1:0]    len_c;
	logic [127:0]                  pat_all;

	logic                          accept;
	logic                          clear;
	logic                          buf_full;
	logic [OB-1:0]                 count_q;
	logic [OB-1:0]                 count_nxt;
	logic [OB-1:0]                 offset;
	logic                          reported_q;
	logic                          match;
	logic                          res_push;
	msbs_pkg::scan_out_t           res_item;

	msbs_pkg::win_entry_t          win_d [PMAX];
	msbs_pkg::win_entry_t          win_q [PMAX];
	msbs_pkg::cell_cfg_t           cell_cfg [PMAX];
	logic [PMAX-1:0]               hit;
	logic [PMAX-1:0]               care_used;
	logic [PMAX-1:0]               win_v;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			care_q   <= '0;
			len_q    <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				msbs_pkg::REG_PAT_LOW:  pat_lo_q <= cfg_data;
				msbs_pkg::REG_PAT_HIGH: pat_hi_q <= cfg_data;
				msbs_pkg::REG_CARE:     care_q   <= cfg_data[15:0];
				msbs_pkg::REG_LENGTH:   len_q    <= cfg_data[msbs_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp length to the window depth
	assign len_c   = (len_q > msbs_pkg::LEN_W'(PMAX)) ? msbs_pkg::LEN_W'(PMAX) : len_q;
	assign pat_all = {pat_hi_q, pat_lo_q};

	assign in_ready = !buf_full;
	assign accept   = in_valid && in_ready;
	assign clear    = accept && in_item.last_byte;

	// Window chain: cell k holds the byte k places back, paired with pattern byte len-1-k
	for (genvar k = 0; k < PMAX; k++) begin : g_cell
		logic       in_use;
		logic [3:0] pidx;

		assign in_use = len_c > msbs_pkg::LEN_W'(k);
		assign pidx   = 4'(len_c - msbs_pkg::LEN_W'(k) - msbs_pkg::LEN_W'(1));

		assign cell_cfg[k] = '{pat:    msbs_pkg::pat_byte(pat_all, pidx),
		                       care:   care_q[pidx],
		                       in_use: in_use};
		assign care_used[k] = in_use && care_q[pidx];
		assign win_v[k]     = win_q[k].valid;

		if (k == 0) begin : g_head
			assign win_d[k] = '{valid: 1'b1, data: in_item.data_byte};
		end else begin : g_body
			assign win_d[k] = win_q[k-1];
		end

		msbs_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (accept),
			.clear  (clear),
			.d      (win_d[k]),
			.cfg    (cell_cfg[k]),
			.q      (win_q[k]),
			.hit    (hit[k])
		);
	end

	// Match on the window as it stands after this byte; needs one cared byte
	assign match = (&hit) && (|care_used);

	// Saturating byte count and start offset of the match
	assign count_nxt = (&count_q) ? count_q : count_q + OB'(1);
	assign offset    = count_nxt - OB'(len_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			reported_q <= 1'b0;
		end else if (accept) begin
			if (in_item.last_byte) begin
				count_q    <= '0;
				reported_q <= 1'b0;
			end else begin
				count_q    <= count_nxt;
				reported_q <= reported_q || match;
			end
		end
	end

	// Raise one result per image: first match, or not-found at the end
	assign res_push = accept && !reported_q && (match || in_item.last_byte);
	assign res_item = '{found:        match,
	                    match_offset: match ? 32'(offset) : 32'd0};

	msbs_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_item (res_item),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// Skid slot fills only behind a waiting output register
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("skid slot occupied with output register empty");

	// Valid bits form an unbroken run from the newest cell
	a_window_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(win_v & (win_v + 1'b1)) == '0)
		else $error("window valid bits not contiguous");

	// End of image empties the window and rearms reporting
	a_image_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		clear |=> (win_v == '0) && !reported_q && (count_q == '0))
		else $error("scan state not cleared after last byte");

endmodule

// ----- bench/tb_masked_byte_signature_scan_top.sv -----
`timescale 1ns / 100ps
// Testbench for the wildcard byte signature scanner: a directed table, then random images.
// Each result request is checked against an in-bench scan window and count model or a
// directed row's typed report. Depends on msbs_pkg and masked_byte_signature_scan_top.
module tb_masked_byte_signature_scan_top;

	localparam int unsigned SEGMENTS          = 8;
	localparam int unsigned ITEMS_PER_SEGMENT = 116;
	localparam int unsigned SETTLE_CYCLES     = 4;
	localparam int unsigned DRAIN_CYCLES      = 8;
	localparam int unsigned IDX_TOP           = (1 << msbs_pkg::CFG_IDX_W) - 1;
	// First index past the register map; catches decoders that alias on the low bits
	localparam logic [msbs_pkg::CFG_IDX_W-1:0] REG_BEYOND_MAP =
		msbs_pkg::CFG_IDX_W'(msbs_pkg::REG_LENGTH) + 1'b1;

	// Idling mix per segment: none, sender only, receiver only, both
	localparam int unsigned SEND_IDLE_PCT [4] = '{0, 68, 0, 28};
	localparam int unsigned RECV_STALL_PCT [4] = '{0, 0, 68, 28};

	typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_e;

	typedef struct {
		row_kind_e                            kind;
		logic [msbs_pkg::CFG_IDX_W-1:0]       reg_index;
		logic [msbs_pkg::CFG_DATA_W-1:0]      reg_value;
		msbs_pkg::scan_in_t                   req;
		bit                                   typed;
		bit                                   typed_has;
		msbs_pkg::scan_out_t                  typed_report;
	} plan_row_t;

	logic                                 clk;
	logic                                 arst_n    = 1'b0;
	logic                                 cfg_valid = 1'b0;
	logic                                 cfg_ready;
	logic [msbs_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
	logic [msbs_pkg::CFG_DATA_W-1:0]      cfg_data  = '0;
	logic                                 in_valid  = 1'b0;
	logic                                 in_ready;
	msbs_pkg::scan_in_t                   in_item   = '0;
	logic                                 out_valid;
	logic                                 out_ready = 1'b0;
	msbs_pkg::scan_out_t                  out_item;

	// Scan model: register copies, byte window (entry 0 newest), count and reported flag
	logic [63:0]                          cfg_pat_low;
	logic [63:0]                          cfg_pat_high;
	logic [15:0]                          cfg_care;
	logic [msbs_pkg::LEN_W-1:0]           cfg_length;
	logic [7:0]                           win [msbs_pkg::PATTERN_MAX];
	logic [msbs_pkg::OFFSET_BITS-1:0]     seen;
	logic                                 reported;

	msbs_pkg::scan_out_t    pending_reports [$];
	plan_row_t              directed_plan [$];
	int unsigned            stall_pct       = 0;
	int unsigned            mismatch_count  = 0;
	int unsigned            reports_checked = 0;
	int unsigned            found_checked   = 0;
	int unsigned            bytes_sent      = 0;
	int unsigned            images_sent     = 0;
	int unsigned            reg_writes      = 0;

	masked_byte_signature_scan_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Give up on a hung handshake
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic logic [7:0] pattern_byte(input int unsigned j);
		logic [8*msbs_pkg::PAT_BYTES-1:0] all;
		all = {cfg_pat_high, cfg_pat_low};
		return all[8*j +: 8];
	endfunction

	function automatic int unsigned active_span();
		return (cfg_length > msbs_pkg::PATTERN_MAX) ? msbs_pkg::PATTERN_MAX : cfg_length;
	endfunction

	function automatic void clear_window_state();
		foreach (win[k])
			win[k] = 8'h00;
		seen = '0;
		reported = 1'b0;
	endfunction

	// Shift one byte in and work out the report it causes, if any
	function automatic void advance_scan(input msbs_pkg::scan_in_t req, output bit has_report,
			output msbs_pkg::scan_out_t report);
		int unsigned span;
		bit          hit;
		bit          any_care;
		span = active_span();
		for (int k = msbs_pkg::PATTERN_MAX - 1; k > 0; k--)
			win[k] = win[k-1];
		win[0] = req.data_byte;
		if (seen != '1)
			seen++;
		has_report = 1'b0;
		report = '0;
		if (!reported) begin
			hit = 1'b0;
			any_care = 1'b0;
			if (span != 0 && seen >= span) begin
				hit = 1'b1;
				for (int j = 0; j < span; j++) begin
					if (cfg_care[j]) begin
						any_care = 1'b1;
						if (win[span-1-j] != pattern_byte(j))
							hit = 1'b0;
					end
				end
			end
			if (hit && any_care) begin
				reported = 1'b1;
				has_report = 1'b1;
				report.found = 1'b1;
				report.match_offset = 32'(seen - span);
			end else if (req.last_byte) begin
				has_report = 1'b1;
			end
		end
		if (req.last_byte)
			clear_window_state();
	endfunction

	function automatic void add_byte_row(input logic [7:0] data, input bit last, input bit typed,
			input bit has, input bit found, input logic [31:0] offset);
		plan_row_t row;
		row.kind = ROW_BYTE;
		row.reg_index = '0;
		row.reg_value = '0;
		row.req.data_byte = data;
		row.req.last_byte = last;
		row.typed = typed;
		row.typed_has = has;
		row.typed_report.found = found;
		row.typed_report.match_offset = offset;
		directed_plan.insert(directed_plan.size(), row);
	endfunction

	function automatic void add_cfg_row(input logic [msbs_pkg::CFG_IDX_W-1:0] index,
			input logic [msbs_pkg::CFG_DATA_W-1:0] value);
		plan_row_t row;
		row.kind = ROW_CFG;
		row.reg_index = index;
		row.reg_value = value;
		row.req = '0;
		row.typed = 1'b0;
		row.typed_has = 1'b0;
		row.typed_report = '0;
		directed_plan.insert(directed_plan.size(), row);
	endfunction

	// Hold the sender low until every pending report has come back
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_reports.size() != 0)
			@(posedge clk);
	endtask

	// Present one byte request; queue its report before the handshake completes
	task automatic send_request(input msbs_pkg::scan_in_t req, input bit typed,
			input bit typed_has, input msbs_pkg::scan_out_t typed_report,
			input int unsigned idle_pct);
		bit                  has;
		msbs_pkg::scan_out_t report;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		advance_scan(req, has, report);
		if (typed) begin
			has = typed_has;
			report = typed_report;
		end
		if (has)
			pending_reports.insert(pending_reports.size(), report);
		in_item <= req;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		bytes_sent++;
	endtask

	// Write one register once the block has gone quiet
	task automatic write_register(input logic [msbs_pkg::CFG_IDX_W-1:0] index,
			input logic [msbs_pkg::CFG_DATA_W-1:0] value);
		hold_until_drained();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		cfg_index <= index;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (index)
			msbs_pkg::REG_PAT_LOW:  cfg_pat_low = value;
			msbs_pkg::REG_PAT_HIGH: cfg_pat_high = value;
			msbs_pkg::REG_CARE:     cfg_care = value[15:0];
			msbs_pkg::REG_LENGTH:   cfg_length = value[msbs_pkg::LEN_W-1:0];
			default:                ;
		endcase
		reg_writes++;
	endtask

	// Pick a register setting per segment; the first few cover the extremes
	task automatic program_segment(input int unsigned seg);
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] care;
		logic [63:0] len;
		lo = {$urandom, $urandom};
		hi = {$urandom, $urandom};
		care = {$urandom, $urandom};
		len = 64'($urandom_range(8, 2));
		case (seg)
			0: begin
				lo = '1;
				hi = '1;
				care = 64'hFFFF;
				len = 64'd16;
			end
			1: len = '1;
			2: begin
				lo = '0;
				hi = '0;
				care = 64'hFFFF;
				len = 64'd1;
			end
			3: begin
				care = 64'hFFFF;
				len = 64'd0;
			end
			5: begin
				care = '0;
				len = 64'($urandom_range(16, 1));
			end
			default: ;
		endcase
		write_register(msbs_pkg::CFG_IDX_W'($urandom_range(IDX_TOP, REG_BEYOND_MAP)),
			{$urandom, $urandom});
		write_register(msbs_pkg::REG_PAT_LOW, lo);
		write_register(msbs_pkg::REG_PAT_HIGH, hi);
		write_register(msbs_pkg::REG_CARE, care);
		write_register(msbs_pkg::REG_LENGTH, len);
	endtask

	// Build one image: mostly the pattern planted in random bytes, sometimes spoilt
	task automatic send_image(input int unsigned idle_pct);
		logic [7:0]         image [$];
		int unsigned        span;
		int unsigned        count;
		int unsigned        at;
		int unsigned        pick;
		msbs_pkg::scan_in_t req;
		span = active_span();
		count = ($urandom_range(9) == 0) ? $urandom_range(60, 25) : $urandom_range(24, 1);
		for (int i = 0; i < count; i++)
			image.insert(image.size(), ($urandom_range(3) == 0)
				? pattern_byte($urandom_range(15)) : 8'($urandom_range(255)));
		pick = $urandom_range(9);
		if (span != 0 && span <= count && pick < 8) begin
			at = (pick == 0) ? count - span : $urandom_range(count - span);
			for (int j = 0; j < span; j++)
				if (cfg_care[j])
					image[at+j] = pattern_byte(j);
			// spoil one planted byte
			if (pick >= 6)
				image[at+$urandom_range(span - 1)] ^= 8'($urandom_range(255, 1));
		end
		images_sent++;
		for (int i = 0; i < count; i++) begin
			req.data_byte = image[i];
			req.last_byte = (i == count - 1);
			send_request(req, 1'b0, 1'b0, '0, idle_pct);
			if ($urandom_range(39) == 0)
				hold_until_drained();
		end
	endtask

	// Compare each accepted result request with the oldest pending report
	always @(posedge clk) begin : check_reports
		msbs_pkg::scan_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_reports.size() == 0) begin
				$display("%0t: report with none pending: found=%0d offset=%0d",
					$time, out_item.found, out_item.match_offset);
				mismatch_count++;
			end else begin
				want = pending_reports.pop_front();
				if (out_item.found !== want.found) begin
					$display("%0t: found mismatch: expected %0d, actual %0d",
						$time, want.found, out_item.found);
					mismatch_count++;
				end
				if (out_item.match_offset !== want.match_offset) begin
					$display("%0t: match_offset mismatch: expected %0d, actual %0d",
						$time, want.match_offset, out_item.match_offset);
					mismatch_count++;
				end
				if (want.found)
					found_checked++;
				reports_checked++;
			end
		end
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	initial begin : stimulus
		int unsigned target;
		int unsigned mode;
		cfg_pat_low = '0;
		cfg_pat_high = '0;
		cfg_care = '0;
		cfg_length = '0;
		clear_window_state();

		// Directed table: reset state, a plain match, post-match bytes, short image,
		// match on the last byte, all wildcards, then a write past the register map
		add_byte_row(8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0);
		add_byte_row(8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 32'd0);
		add_cfg_row(msbs_pkg::REG_PAT_LOW, 64'h0000_0000_DDCC_BBAA);
		add_cfg_row(msbs_pkg::REG_PAT_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
		add_cfg_row(msbs_pkg::REG_CARE, 64'hFFFF_FFFF_FFFF_FFFF);
		add_cfg_row(msbs_pkg::REG_LENGTH, 64'd4);
		add_byte_row(8'h11, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
		add_byte_row(8'hAA, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
		add_byte_row(8'hBB, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
		add_byte_row(8'hCC, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
		add_byte_row(8'hDD, 1'b0, 1'b1, 1'b1, 1'b1, 32'd1);
		add_byte_row(8'hAA, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
		add_byte_row(8'hBB, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
		add_byte_row(8'hCC, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
		add_byte_row(8'hDD, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0);
		add_byte_row(8'hAA, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
		add_byte_row(8'hBB, 1'b1, 1'b1, 1'b1, 1'b0, 32'd0);
		add_byte_row(8'hAA, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
		add_byte_row(8'hBB, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
		add_byte_row(8'hCC, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
		add_byte_row(8'hDD, 1'b1, 1'b1, 1'b1, 1'b1, 32'd0);
		add_cfg_row(msbs_pkg::REG_CARE, 64'd0);
		add_byte_row(8'hAA, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
		add_byte_row(8'hBB, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
		add_byte_row(8'hCC, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
		add_byte_row(8'hDD, 1'b1, 1'b1, 1'b1, 1'b0, 32'd0);
		add_cfg_row(msbs_pkg::REG_CARE, 64'hFFFF);
		add_cfg_row(REG_BEYOND_MAP, 64'd0);
		add_byte_row(8'hAA, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
		add_byte_row(8'hBB, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
		add_byte_row(8'hCC, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
		add_byte_row(8'hDD, 1'b1, 1'b1, 1'b1, 1'b1, 32'd0);

		// Hold reset, then release at an edge
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table with no idling
		foreach (directed_plan[i]) begin
			if (directed_plan[i].kind == ROW_CFG) begin
				write_register(directed_plan[i].reg_index, directed_plan[i].reg_value);
			end else begin
				send_request(directed_plan[i].req, directed_plan[i].typed,
					directed_plan[i].typed_has, directed_plan[i].typed_report, 0);
			end
		end

		// Random images over several settings and idling mixes
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			program_segment(seg);
			mode = seg % 4;
			stall_pct = RECV_STALL_PCT[mode];
			target = bytes_sent + ITEMS_PER_SEGMENT;
			while (bytes_sent < target)
				send_image(SEND_IDLE_PCT[mode]);
		end

		// Drain and let the pipeline settle
		hold_until_drained();
		stall_pct = 0;
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("Scanned %0d bytes in %0d random images plus the directed table.",
			bytes_sent, images_sent);
		$display("Compared %0d reports (%0d matches) after %0d register writes.",
			reports_checked, found_checked, reg_writes);
		if (mismatch_count == 0 && pending_reports.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
